@@ hdl/fgft_pkg.sv @@
package fgft_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LSEARCH,
        ST_RSEARCH,
        ST_SETX,
        ST_SETQ,
        ST_QMAX,
        ST_OUT
    } fgft_state_t;

    localparam logic OP_PLACE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the input item
        logic clr_step;    // clear one entry, advance the clear address
        logic lscan_start;
        logic lscan_step;
        logic rscan_start;
        logic rscan_step;
        logic tree_start_x;
        logic tree_start_q;
        logic tree_step;
        logic qmax_start;
        logic qmax_step;
        logic mark_set;
        logic out_load;
    } fgft_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op;
        logic skip_place;  // out of range or already an obstacle
        logic clr_done;
        logic lscan_done;
        logic rscan_done;
        logic rfound;
        logic tree_done;
        logic qmax_done;
    } fgft_stat_t;

endpackage

@@ hdl/free_gap_fit_tracker.sv @@
// free_gap_fit_tracker: obstacle line with max-gap tree and fit queries.
// Left search: walks the marks downward from x, one mark read per cycle; a query then
//   runs a prefix max over the tree and then presents its result.
// Items are taken one at a time; placement adds two tree walks and a right search
//   for the next obstacle.
// Reset: asynchronous, active low; a clearing pass of marks and tree follows.
module free_gap_fit_tracker #(
    parameter int MAX_POS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // opcode[0], position[12:1], block_size[24:13]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // fits[0]
);
    import fgft_pkg::*;

    fgft_cmd_t  cmd;
    fgft_stat_t stat;
    logic       load_out;
    logic       out_full;
    logic       fits;
    logic       out_valid_reg;

    // hold the finished query while the previous result still waits
    assign out_full = out_valid_reg && !m_axis_tready;

    fgft_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .out_full      (out_full),
        .m_valid_load  (load_out),
        .stat          (stat),
        .cmd           (cmd)
    );

    fgft_dpath #(.MAX_POS(MAX_POS)) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (s_axis_tdata[24:0]),
        .cmd     (cmd),
        .stat    (stat),
        .fits    (fits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, fits};

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || m_axis_tready))
        else $error("result overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while held");

endmodule

@@ hdl/fgft_ctrl.sv @@
module fgft_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic                out_full,
    output logic                m_valid_load,
    input  fgft_pkg::fgft_stat_t stat,
    output fgft_pkg::fgft_cmd_t  cmd
);
    import fgft_pkg::*;

    fgft_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_LSEARCH;
                end
            end
            ST_LSEARCH:
            begin
                if (stat.lscan_done)
                begin
                    if (stat.op == OP_QUERY)
                    begin
                        state_next = ST_QMAX;
                    end
                    else if (stat.skip_place)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SETX;
                    end
                end
            end
            ST_SETX:
            begin
                if (stat.tree_done)
                begin
                    state_next = ST_RSEARCH;
                end
            end
            ST_RSEARCH:
            begin
                if (stat.rscan_done)
                begin
                    state_next = stat.rfound ? ST_SETQ : ST_IDLE;
                end
            end
            ST_SETQ:
            begin
                if (stat.tree_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QMAX:
            begin
                if (stat.qmax_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        m_valid_load  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                s_axis_tready   = 1'b1;
                cmd.load        = s_axis_tvalid;
                cmd.lscan_start = s_axis_tvalid;
            end
            ST_LSEARCH:
            begin
                cmd.lscan_step = 1'b1;
                if (stat.lscan_done)
                begin
                    cmd.tree_start_x = (stat.op == OP_PLACE) && !stat.skip_place;
                    cmd.qmax_start   = (stat.op == OP_QUERY);
                end
            end
            ST_SETX:
            begin
                cmd.tree_step = 1'b1;
                if (stat.tree_done)
                begin
                    cmd.rscan_start = 1'b1;
                end
            end
            ST_RSEARCH:
            begin
                cmd.rscan_step = 1'b1;
                if (stat.rscan_done)
                begin
                    cmd.tree_start_q = stat.rfound;
                    cmd.mark_set     = !stat.rfound;
                end
            end
            ST_SETQ:
            begin
                cmd.tree_step = 1'b1;
                cmd.mark_set  = stat.tree_done;
            end
            ST_QMAX:
            begin
                cmd.qmax_step = 1'b1;
            end
            ST_OUT:
            begin
                cmd.out_load = !out_full;
                m_valid_load = !out_full;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !out_full) |=> (state_reg == ST_IDLE))
        else $error("result state not left");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mark_set) |-> (state_reg == ST_RSEARCH || state_reg == ST_SETQ))
        else $error("mark written outside placement");

endmodule

@@ hdl/fgft_dpath.sv @@
module fgft_dpath #(
    parameter int MAX_POS = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [24:0]          in_data,
    input  fgft_pkg::fgft_cmd_t  cmd,
    output fgft_pkg::fgft_stat_t stat,
    output logic                 fits
);
    import fgft_pkg::*;

    localparam int LW = $clog2(MAX_POS);       // leaf index bits
    localparam int NW = LW + 1;                // tree node index bits
    localparam int MW = 16;                    // gap value width (values up to 65535)

    // item
    logic        op_reg;
    logic [11:0] x_reg;
    logic [11:0] sz_reg;

    // obstacle marks: memory, one bit per position; cleared by sweep
    logic        mark_mem [MAX_POS];
    logic [MW-1:0] tree_mem [2*MAX_POS];

    logic [NW:0]   clr_reg;
    logic          x_in;                        // x < MAX_POS
    logic [LW-1:0] xi;

    assign x_in = ({5'd0, x_reg} < 17'(MAX_POS));
    assign xi   = LW'(x_reg);

    // left search: walk p downward, mark read registered
    logic [LW:0]   lp_reg;     // current probe address + 1
    logic [LW-1:0] left_reg;
    logic          lbusy_reg, lpend_reg, lfirst_reg;
    logic          xmark_reg;
    logic          mrd_reg;
    logic [LW-1:0] mrd_addr;
    logic          mrd_en;
    // right search
    logic [LW:0]   rp_reg;
    logic          rfound_reg;
    logic          rpend_reg;
    // tree update
    logic [NW-1:0] ti_reg;
    logic [MW-1:0] tv_reg;
    logic          tph_reg;    // 0: read sibling, 1: write parent
    logic          tbusy_reg;
    logic          tdone;
    logic [MW-1:0] trd_reg;
    // prefix max
    logic [NW:0]   ql_reg, qr_reg;
    logic [MW-1:0] best_reg;
    logic [1:0]    qph_reg;
    logic          qdone;
    logic [MW-1:0] trail_reg;

    logic          t_we;
    logic [NW-1:0] t_waddr, t_raddr;
    logic [MW-1:0] t_wdata;

    // mark memory port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            mark_mem[LW'(clr_reg)] <= (LW'(clr_reg) == '0);
        end
        else if (cmd.mark_set)
        begin
            mark_mem[xi] <= 1'b1;
        end
        if (mrd_en)
        begin
            mrd_reg <= mark_mem[mrd_addr];
        end
    end

    // tree memory port
    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tree_mem[t_waddr] <= t_wdata;
        end
        trd_reg <= tree_mem[t_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_step && clr_reg < (NW+1)'(2*MAX_POS))
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end
    assign stat.clr_done = (clr_reg == (NW+1)'(2*MAX_POS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_data[0];
            x_reg  <= in_data[12:1];
            sz_reg <= in_data[24:13];
        end
    end

    // left search and own mark read share the mark read port
    // lfirst: first probe reads mark[x] (placement check)
    always_comb
    begin
        mrd_en   = 1'b0;
        mrd_addr = '0;
        if (cmd.lscan_step && lbusy_reg && lfirst_reg)
        begin
            mrd_en   = 1'b1;
            mrd_addr = x_in ? xi : '0;
        end
        else if (cmd.lscan_step && lbusy_reg && lp_reg != '0)
        begin
            mrd_en   = 1'b1;
            mrd_addr = LW'(lp_reg - 1'b1);
        end
        else if (cmd.rscan_step && !rfound_reg && rp_reg < (LW+1)'(MAX_POS))
        begin
            mrd_en   = 1'b1;
            mrd_addr = LW'(rp_reg);
        end
    end

    logic [LW:0] xs;
    assign xs = x_in ? (LW+1)'(x_reg) : (LW+1)'(MAX_POS);

    always_ff @(posedge clk)
    begin
        if (cmd.lscan_start)
        begin
            lbusy_reg  <= 1'b1;
            lfirst_reg <= 1'b1;
            lpend_reg  <= 1'b0;
            left_reg   <= '0;
        end
        else if (cmd.lscan_step)
        begin
            if (lfirst_reg)
            begin
                lfirst_reg <= 1'b0;
                lp_reg     <= xs;
                lpend_reg  <= 1'b1;
                xmark_reg  <= 1'b0;
            end
            else
            begin
                if (lpend_reg && xmark_reg == 1'b0 && lp_reg == xs)
                begin
                    xmark_reg <= mrd_reg & x_in;
                end
                // result of previous probe at lp_reg (p = lp_reg)
                if (lpend_reg && lp_reg != xs && mrd_reg)
                begin
                    lbusy_reg <= 1'b0;
                    left_reg  <= LW'(lp_reg);
                end
                else if (lp_reg == '0)
                begin
                    lbusy_reg <= 1'b0;
                end
                else
                begin
                    lp_reg <= lp_reg - 1'b1;
                end
            end
        end
    end

    // lscan done: stopped (lbusy low) after first probe
    assign stat.lscan_done = cmd.lscan_step && !lbusy_reg;
    assign stat.op         = op_reg;
    assign stat.skip_place = !x_in || xmark_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rscan_start)
        begin
            rp_reg     <= (LW+1)'(x_reg) + 1'b1;
            rfound_reg <= 1'b0;
            rpend_reg  <= 1'b0;
        end
        else if (cmd.rscan_step && !rfound_reg)
        begin
            if (rpend_reg && mrd_reg)
            begin
                rfound_reg <= 1'b1;
                rp_reg     <= rp_reg - 1'b1;
            end
            else if (rp_reg < (LW+1)'(MAX_POS))
            begin
                rp_reg    <= rp_reg + 1'b1;
                rpend_reg <= 1'b1;
            end
            else
            begin
                rp_reg <= rp_reg + 1'b1;
            end
        end
    end
    assign stat.rfound     = rfound_reg;
    assign stat.rscan_done = cmd.rscan_step &&
                             (rfound_reg || rp_reg > (LW+1)'(MAX_POS));

    // tree walk: write leaf, then per level read sibling, write parent
    always_comb
    begin
        t_we    = 1'b0;
        t_waddr = ti_reg;
        t_wdata = tv_reg;
        t_raddr = ti_reg ^ NW'(1);
        if (cmd.clr_step)
        begin
            t_we    = 1'b1;
            t_waddr = NW'(clr_reg);
            t_wdata = '0;
        end
        else if (cmd.tree_step && tbusy_reg && tph_reg)
        begin
            t_we    = 1'b1;
            t_waddr = ti_reg;
            t_wdata = tv_reg;
        end
        else if (cmd.qmax_step)
        begin
            t_raddr = (qph_reg == 2'd0) ? NW'(ql_reg) : NW'(qr_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tree_start_x || cmd.tree_start_q)
        begin
            tbusy_reg <= 1'b1;
            tph_reg   <= 1'b1;
            ti_reg    <= NW'(MAX_POS) + (cmd.tree_start_x ? NW'(xi) : NW'(rp_reg));
            tv_reg    <= cmd.tree_start_x ? MW'(x_reg) - MW'(left_reg)
                                          : MW'(rp_reg) - MW'(x_reg);
        end
        else if (cmd.tree_step && tbusy_reg)
        begin
            if (tph_reg)
            begin
                if (ti_reg == NW'(1))
                begin
                    tbusy_reg <= 1'b0;
                end
                tph_reg <= 1'b0;
            end
            else
            begin
                tph_reg <= 1'b1;
                ti_reg  <= ti_reg >> 1;
                tv_reg  <= (trd_reg > tv_reg) ? trd_reg : tv_reg;
            end
        end
    end
    // sibling read issued in write phase, data valid in next phase
    assign tdone = cmd.tree_step && !tbusy_reg;
    assign stat.tree_done = tdone;

    // prefix max: phase 0 read l, 1 read r-1 / use l, 2 use r, shift
    logic [LW:0] hi;
    assign hi = x_in ? (LW+1)'(x_reg) : (LW+1)'(MAX_POS - 1);

    always_ff @(posedge clk)
    begin
        if (cmd.qmax_start)
        begin
            ql_reg    <= (NW+1)'(MAX_POS);
            qr_reg    <= (NW+1)'(MAX_POS) + (NW+1)'(hi) + 1'b1;
            best_reg  <= '0;
            qph_reg   <= 2'd0;
            trail_reg <= MW'(x_reg) - MW'(left_reg);
        end
        else if (cmd.qmax_step && ql_reg < qr_reg)
        begin
            case (qph_reg)
                2'd0:
                begin
                    qph_reg <= 2'd1;
                end
                2'd1:
                begin
                    if (ql_reg[0] && trd_reg > best_reg)
                    begin
                        best_reg <= trd_reg;
                    end
                    qph_reg <= 2'd2;
                end
                2'd2:
                begin
                    if (qr_reg[0] && trd_reg > best_reg)
                    begin
                        best_reg <= trd_reg;
                    end
                    ql_reg  <= (ql_reg + (NW+1)'(ql_reg[0])) >> 1;
                    qr_reg  <= qr_reg >> 1;
                    qph_reg <= 2'd0;
                end
                default:
                begin
                    qph_reg <= 2'd0;
                end
            endcase
        end
    end
    assign qdone = cmd.qmax_step && !(ql_reg < qr_reg);
    assign stat.qmax_done = qdone;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            fits <= (trail_reg >= MW'(sz_reg)) || (best_reg >= MW'(sz_reg));
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tree_step |-> !cmd.qmax_step)
        else $error("tree port shared");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mark_set) |-> x_in)
        else $error("mark out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !cmd.load)
        else $error("double load");

endmodule
